FILE: rtl/core/assert_macros.svh
// assertion macros shared by the matrix-vector transform rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock edge, switched off during reset
`define MVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen
`define MVT_NEVER(label, cond, msg) \
  `MVT_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/core/mvt_pkg.sv
// shared types and constants for the matrix-vector transform
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int unsigned DIM           = 5;
  localparam int unsigned NUM_ENTRIES   = DIM * DIM;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CMD_Q_DEPTH   = 2;
  localparam int unsigned RES_Q_DEPTH   = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic [IDX_W-1:0]            idx;
    logic [DATA_W-1:0]           value;
    logic [DIM-1:0][DATA_W-1:0]  vec;
  } work_item_t;

  typedef struct packed {
    logic [DIM-1:0][DATA_W-1:0]  elem;
    logic                        sat;
  } result_t;

endpackage

FILE: rtl/core/mvt_front.sv
// front end: accepts transactions, drops bad loads, queues work for the back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               op_in,
  input  logic [mvt_pkg::IDX_W-1:0]          idx_in,
  input  logic [mvt_pkg::DATA_W-1:0]         value_in,
  input  logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] vec_in,
  output logic                               q_valid,
  output mvt_pkg::work_item_t                q_item,
  input  logic                               q_pop
);
  import mvt_pkg::*;

  localparam int unsigned PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_Q_DEPTH + 1);

  work_item_t       q_mem_r [CMD_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             keep;
  work_item_t       item_new;

  assign full    = (count_r == CNT_W'(CMD_Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  // loads outside the matrix are dropped here
  always_comb begin
    item_new.op    = op_t'(op_in);
    item_new.idx   = idx_in;
    item_new.value = value_in;
    item_new.vec   = vec_in;
    accept = push && !full;
    keep   = accept && ((item_new.op == OP_XFORM) || (idx_in < IDX_W'(NUM_ENTRIES)));
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (keep) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(keep) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_mem_r[wr_ptr_r] <= item_new;
    end
  end

  `MVT_ASSERT(a_cmd_q_bound, count_r <= CNT_W'(CMD_Q_DEPTH), "command queue count past depth")
  `MVT_NEVER(a_cmd_q_pop_empty, q_pop && (count_r == '0), "command queue popped while empty")

endmodule

FILE: rtl/core/mvt_back.sv
// back end: matrix store, multiplier array and saturating adders
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_back #(
  parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        side,
  input  logic                                        q_valid,
  input  mvt_pkg::work_item_t                         q_item,
  output logic                                        q_pop,
  input  logic [$clog2(mvt_pkg::RES_Q_DEPTH + 1)-1:0] res_level,
  output logic                                        res_wr,
  output mvt_pkg::result_t                            res_data
);
  import mvt_pkg::*;

  localparam int unsigned LVL_W  = $clog2(RES_Q_DEPTH + 1);
  localparam int unsigned OCC_W  = LVL_W + 1;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W - FRAC_BITS + 3;
  localparam logic [DATA_W-1:0] DIAG = DATA_W'(64'd1 << FRAC_BITS);

  logic [DATA_W-1:0]        mat_r [NUM_ENTRIES];
  logic signed [PROD_W-1:0] prod_r   [DIM][DIM];
  logic signed [PROD_W-1:0] prod_nxt [DIM][DIM];
  logic signed [SUM_W-1:0]  psum_a_r [DIM];
  logic signed [SUM_W-1:0]  psum_b_r [DIM];
  logic signed [SUM_W-1:0]  psum_a_nxt [DIM];
  logic signed [SUM_W-1:0]  psum_b_nxt [DIM];
  logic                     v1_r, v2_r;
  logic [OCC_W-1:0]         occ;
  logic                     credit_ok;
  logic                     do_load;
  logic                     do_xform;

  // room in the result queue for everything already in the pipe
  assign occ = OCC_W'(res_level) + OCC_W'(v1_r) + OCC_W'(v2_r);
  assign credit_ok = (occ < OCC_W'(RES_Q_DEPTH));
  assign do_load   = q_valid && (q_item.op == OP_LOAD);
  assign do_xform  = q_valid && (q_item.op == OP_XFORM) && credit_ok;
  assign q_pop     = do_load || do_xform;

  // stage 1: one multiplier per matrix entry, side picks plain or transposed
  always_comb begin
    logic [DATA_W-1:0] m_sel;
    m_sel = '0;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        m_sel = side ? mat_r[j * DIM + i] : mat_r[i * DIM + j];
        prod_nxt[i][j] = $signed(m_sel) * $signed(q_item.vec[j]);
      end
    end
  end

  // stage 2: floor shift then two partial sums per row
  always_comb begin
    logic signed [PROD_W-1:0] sh;
    logic signed [SUM_W-1:0]  t [DIM];
    sh = '0;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        sh   = prod_r[i][j] >>> FRAC_BITS;
        t[j] = sh[SUM_W-1:0];
      end
      psum_a_nxt[i] = t[0] + t[1] + t[2];
      psum_b_nxt[i] = t[3] + t[4];
    end
  end

  // stage 3: final add and clip to 32 bits
  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic                    ovf;
    s = '0;
    res_data.sat = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      s   = psum_a_r[i] + psum_b_r[i];
      ovf = !((&s[SUM_W-1:DATA_W-1]) || (~|s[SUM_W-1:DATA_W-1]));
      if (ovf) begin
        res_data.elem[i] = s[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        res_data.elem[i] = s[DATA_W-1:0];
      end
      res_data.sat = res_data.sat | ovf;
    end
  end
  assign res_wr = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          mat_r[i * DIM + j] <= (i == j) ? DIAG : '0;
        end
      end
    end else if (do_load) begin
      mat_r[q_item.idx] <= q_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= do_xform;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_xform) begin
      prod_r <= prod_nxt;
    end
    if (v1_r) begin
      psum_a_r <= psum_a_nxt;
      psum_b_r <= psum_b_nxt;
    end
  end

  `MVT_ASSERT(a_credit_bound, occ <= OCC_W'(RES_Q_DEPTH), "result credit overrun")
  `MVT_NEVER(a_load_with_xform, do_load && do_xform, "load and transform issued together")

endmodule

FILE: rtl/core/mvt_res_fifo.sv
// result queue between the back end and the output port
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_res_fifo (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        wr_en,
  input  mvt_pkg::result_t                            wr_data,
  input  logic                                        rd_en,
  output mvt_pkg::result_t                            rd_data,
  output logic                                        empty,
  output logic [$clog2(mvt_pkg::RES_Q_DEPTH + 1)-1:0] level
);
  import mvt_pkg::*;

  localparam int unsigned PTR_W = (RES_Q_DEPTH > 1) ? $clog2(RES_Q_DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(RES_Q_DEPTH + 1);

  result_t          mem_r [RES_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_rd;

  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(RES_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(RES_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    level_nxt = level_r + LVL_W'(wr_en) - LVL_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `MVT_NEVER(a_res_overflow, wr_en && (level_r == LVL_W'(RES_Q_DEPTH)),
             "result written into full queue")

endmodule

FILE: rtl/core/matrix_vector_transform_5x5_unit.sv
// top level of the 5x5 matrix-vector transform
`timescale 1ns / 1ps

// usage
//   input channel: a transaction is taken when push is high and full is low. operation 0
//   loads entry_value into the matrix at entry_index (row*5+column, 25..31 ignored) and
//   gives no result; operation 1 multiplies the matrix by vec_0..vec_4
//   result channel: while empty is low the oldest result sits on out_0..out_4 and
//   out_saturated; pop with empty low takes it
//   cfg_wr_en writes cfg_wr_data into the side select (0 matrix, 1 transposed) at once;
//   write it only while the block is idle
//   path: command queue, multiplier array, partial sums, final add into the result queue
//   throughput: one transaction per cycle, loads and transforms alike, while full is low;
//   a transform waits while the result queue has no free slot; the 25 multipliers work
//   in parallel and each stage takes a new item every cycle
//   reset: matrix returns to identity (1.0 on the diagonal), side select to 0, both
//   queues empty
//   stalls: the result queue holds four transactions and the back end only issues a
//   transform when its slot is reserved; with pop held low the pipe drains into the
//   queue, the two-entry command queue fills and full rises, with nothing lost
module matrix_vector_transform_5x5_unit #(
  parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              push,
  output logic                              full,
  input  logic                              in_operation,
  input  logic [mvt_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_entry_value,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_vec_0,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_vec_1,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_vec_2,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_vec_3,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_vec_4,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mvt_pkg::DATA_W-1:0] out_0,
  output logic signed [mvt_pkg::DATA_W-1:0] out_1,
  output logic signed [mvt_pkg::DATA_W-1:0] out_2,
  output logic signed [mvt_pkg::DATA_W-1:0] out_3,
  output logic signed [mvt_pkg::DATA_W-1:0] out_4,
  output logic                              out_saturated,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);
  import mvt_pkg::*;

  localparam int unsigned LVL_W = $clog2(RES_Q_DEPTH + 1);

  logic                        side_r;
  logic [DIM-1:0][DATA_W-1:0]  vec_in;
  logic                        q_valid;
  work_item_t                  q_item;
  logic                        q_pop;
  logic [LVL_W-1:0]            res_level;
  logic                        res_wr;
  result_t                     res_data;
  result_t                     res_head;

  // side select register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= 1'b0;
    end else if (cfg_wr_en) begin
      side_r <= cfg_wr_data;
    end
  end

  // gather the vector into one packed word
  assign vec_in[0] = in_vec_0;
  assign vec_in[1] = in_vec_1;
  assign vec_in[2] = in_vec_2;
  assign vec_in[3] = in_vec_3;
  assign vec_in[4] = in_vec_4;

  // front end: takes transactions and queues the ones with work to do
  mvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .op_in    (in_operation),
    .idx_in   (in_entry_index),
    .value_in (in_entry_value),
    .vec_in   (vec_in),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back end: matrix store and the three-stage arithmetic pipe
  mvt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .side      (side_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_level (res_level),
    .res_wr    (res_wr),
    .res_data  (res_data)
  );

  // result queue decouples the pipe from the receiver
  mvt_res_fifo u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_data),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty),
    .level   (res_level)
  );

  assign out_0         = $signed(res_head.elem[0]);
  assign out_1         = $signed(res_head.elem[1]);
  assign out_2         = $signed(res_head.elem[2]);
  assign out_3         = $signed(res_head.elem[3]);
  assign out_4         = $signed(res_head.elem[4]);
  assign out_saturated = res_head.sat;

endmodule
